// ===== rtl/e2h_pkg.sv =====
// Package for the equatorial to horizontal converter.
// Holds the fixed-point types, the CORDIC arctangent table and the pipeline latencies.
// Used by every file below but tb_e2h_if.sv; it depends on nothing.
package e2h_pkg;

  localparam int STEPS       = 30;
  localparam int SQRT_STEPS  = 32;
  localparam int NORM_STAGES = 5;
  localparam int CW          = 36;

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [31:0]   q30_t;
  typedef logic [31:0]          turn_t;
  typedef logic signed [63:0]   wide_t;
  typedef logic [63:0]          uwide_t;
  typedef logic signed [32:0]   nval_t;
  typedef logic [4:0]           step_t;

  localparam turn_t QUARTER_TURN = 32'h4000_0000;
  localparam turn_t HALF_TURN    = 32'h8000_0000;
  localparam cval_t ONE_C        = 36'sd1073741824;
  localparam wide_t ONE_W        = 64'sd1073741824;
  localparam cval_t ROT_GAIN     = 36'sd652032874;
  localparam uwide_t ONE_SQ      = 64'h1000_0000_0000_0000;

  localparam int SINCOS_LAT = STEPS + 2;
  localparam int VECTOR_LAT = 1 + NORM_STAGES + STEPS;
  localparam int PROD_LAT   = 5;
  localparam int AZPRE_LAT  = 4;
  localparam int TOTAL_LAT  = 1 + SINCOS_LAT + PROD_LAT + SQRT_STEPS + AZPRE_LAT
                              + SQRT_STEPS + VECTOR_LAT + 1;
  localparam int ALT_DLY    = AZPRE_LAT + SQRT_STEPS;
  localparam int AZS_DLY    = SQRT_STEPS + VECTOR_LAT;

  typedef enum logic [1:0] {
    AZ_ZERO,
    AZ_HALF,
    AZ_ACOS
  } az_code_e;

  typedef struct packed {
    q30_t sd;
    q30_t sl;
    q30_t cl;
    logic sh_pos;
  } trig_t;

  typedef struct packed {
    q30_t  sa;
    trig_t tg;
  } side_t;

  typedef struct packed {
    nval_t    n;
    az_code_e code;
    logic     sh_pos;
  } az_side_t;

  function automatic cval_t atan_turn(step_t i);
    cval_t r;
    case (i)
      5'd0:  r = 36'sd536870912;
      5'd1:  r = 36'sd316933406;
      5'd2:  r = 36'sd167458907;
      5'd3:  r = 36'sd85004756;
      5'd4:  r = 36'sd42667331;
      5'd5:  r = 36'sd21354465;
      5'd6:  r = 36'sd10679838;
      5'd7:  r = 36'sd5340245;
      5'd8:  r = 36'sd2670163;
      5'd9:  r = 36'sd1335087;
      5'd10: r = 36'sd667544;
      5'd11: r = 36'sd333772;
      5'd12: r = 36'sd166886;
      5'd13: r = 36'sd83443;
      5'd14: r = 36'sd41722;
      5'd15: r = 36'sd20861;
      5'd16: r = 36'sd10430;
      5'd17: r = 36'sd5215;
      5'd18: r = 36'sd2608;
      5'd19: r = 36'sd1304;
      5'd20: r = 36'sd652;
      5'd21: r = 36'sd326;
      5'd22: r = 36'sd163;
      5'd23: r = 36'sd81;
      5'd24: r = 36'sd41;
      5'd25: r = 36'sd20;
      5'd26: r = 36'sd10;
      5'd27: r = 36'sd5;
      5'd28: r = 36'sd3;
      5'd29: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q30_t clamp_q30(cval_t v);
    q30_t r;
    if (v > ONE_C) begin
      r = q30_t'(ONE_C);
    end else if (v < -ONE_C) begin
      r = q30_t'(-ONE_C);
    end else begin
      r = q30_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/e2h_if.sv =====
// Handshake channels of the equatorial to horizontal converter.
// Depends on e2h_pkg for the payload types.
interface e2h_in_if;
  logic                valid;
  logic                ready;
  e2h_pkg::turn_t      right_ascension;
  e2h_pkg::q30_t       declination;
  e2h_pkg::turn_t      local_sidereal_time;
  modport source (output valid, output right_ascension, output declination,
                  output local_sidereal_time, input ready);
  modport sink (input valid, input right_ascension, input declination,
                input local_sidereal_time, output ready);
endinterface

interface e2h_out_if;
  logic           valid;
  logic           ready;
  e2h_pkg::q30_t  altitude;
  e2h_pkg::turn_t azimuth;
  modport source (output valid, output altitude, output azimuth, input ready);
  modport sink (input valid, input altitude, input azimuth, output ready);
endinterface

interface e2h_cfg_if;
  logic          valid;
  logic          ready;
  e2h_pkg::q30_t observer_latitude;
  modport source (output valid, output observer_latitude, input ready);
  modport sink (input valid, input observer_latitude, output ready);
endinterface

// ===== rtl/e2h_cordic_cell.sv =====
// One CORDIC micro-rotation, in rotation or vectoring mode, with its own registers.
// Depends on e2h_pkg for the value type and the arctangent table.
module e2h_cordic_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           vec_mode_i,
  input  e2h_pkg::step_t step_i,
  input  e2h_pkg::cval_t x_i,
  input  e2h_pkg::cval_t y_i,
  input  e2h_pkg::cval_t z_i,
  output e2h_pkg::cval_t x_o,
  output e2h_pkg::cval_t y_o,
  output e2h_pkg::cval_t z_o
);

  e2h_pkg::cval_t x_d, y_d, z_d, x_q, y_q, z_q, dx, dy, at;
  logic dir;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    at  = e2h_pkg::atan_turn(step_i);
    dir = vec_mode_i ? (y_i <= 0) : (z_i >= 0);
    if (dir) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - at;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/e2h_sqrt_cell.sv =====
// One digit of the bitwise integer square root, with its own registers.
// Depends on e2h_pkg for the wide unsigned type.
module e2h_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  e2h_pkg::step_t  step_i,
  input  e2h_pkg::uwide_t v_i,
  input  e2h_pkg::uwide_t r_i,
  output e2h_pkg::uwide_t v_o,
  output e2h_pkg::uwide_t r_o
);

  e2h_pkg::uwide_t b, rb, v_d, r_d, v_q, r_q;
  logic [6:0] sh;

  always_comb begin
    sh = 7'd62 - {1'b0, step_i, 1'b0};
    b  = 64'd1 << sh;
    rb = r_i + b;
    if (v_i >= rb) begin
      v_d = v_i - rb;
      r_d = (r_i >> 1) + b;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

// ===== rtl/e2h_sincos.sv =====
// Sine and cosine of a turn angle through a chain of rotation cells.
// Depends on e2h_pkg and e2h_cordic_cell.
module e2h_sincos (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2h_pkg::turn_t a_i,
  output e2h_pkg::q30_t  sin_o,
  output e2h_pkg::q30_t  cos_o
);

  localparam int N = e2h_pkg::STEPS;

  e2h_pkg::cval_t cx [N+1];
  e2h_pkg::cval_t cy [N+1];
  e2h_pkg::cval_t cz [N+1];
  logic           neg_q [N+1];
  e2h_pkg::cval_t z0_q;
  e2h_pkg::turn_t a_red;
  logic           neg_d;
  e2h_pkg::q30_t  xc, yc, sin_d, cos_d, sin_q, cos_q;

  always_comb begin
    neg_d = a_i[31] ^ a_i[30];
    a_red = neg_d ? (a_i - e2h_pkg::HALF_TURN) : a_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q     <= {{(e2h_pkg::CW-32){a_red[31]}}, a_red};
      neg_q[0] <= neg_d;
      for (int k = 1; k <= N; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign cx[0] = e2h_pkg::ROT_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z0_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    e2h_cordic_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (en_i),
      .vec_mode_i (1'b0),
      .step_i     (e2h_pkg::step_t'(k)),
      .x_i        (cx[k]),
      .y_i        (cy[k]),
      .z_i        (cz[k]),
      .x_o        (cx[k+1]),
      .y_o        (cy[k+1]),
      .z_o        (cz[k+1])
    );
  end

  always_comb begin
    xc    = e2h_pkg::clamp_q30(cx[N]);
    yc    = e2h_pkg::clamp_q30(cy[N]);
    cos_d = neg_q[N] ? -xc : xc;
    sin_d = neg_q[N] ? -yc : yc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== rtl/e2h_vector.sv =====
// Angle of a vector: quadrant fold, staged normalizing shift, then vectoring cells.
// Depends on e2h_pkg and e2h_cordic_cell.
module e2h_vector (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2h_pkg::cval_t x_i,
  input  e2h_pkg::cval_t y_i,
  output e2h_pkg::cval_t z_o
);

  localparam int N = e2h_pkg::STEPS;
  localparam int M = e2h_pkg::NORM_STAGES;

  e2h_pkg::cval_t nx_q [M+1];
  e2h_pkg::cval_t ny_q [M+1];
  e2h_pkg::cval_t nz_q [M+1];
  e2h_pkg::cval_t cx [N+1];
  e2h_pkg::cval_t cy [N+1];
  e2h_pkg::cval_t cz [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        nx_q[0] <= y_i;
        ny_q[0] <= -x_i;
        nz_q[0] <= e2h_pkg::cval_t'(e2h_pkg::QUARTER_TURN);
      end else begin
        nx_q[0] <= x_i;
        ny_q[0] <= y_i;
        nz_q[0] <= '0;
      end
    end
  end

  for (genvar j = 0; j < M; j++) begin : g_norm
    localparam int SH = 16 >> j;
    localparam e2h_pkg::cval_t LIM = e2h_pkg::cval_t'(64'd1 << (30 - SH));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (nx_q[j] < LIM && ny_q[j] < LIM && ny_q[j] > -LIM) begin
          nx_q[j+1] <= nx_q[j] <<< SH;
          ny_q[j+1] <= ny_q[j] <<< SH;
        end else begin
          nx_q[j+1] <= nx_q[j];
          ny_q[j+1] <= ny_q[j];
        end
        nz_q[j+1] <= nz_q[j];
      end
    end
  end

  assign cx[0] = nx_q[M];
  assign cy[0] = ny_q[M];
  assign cz[0] = nz_q[M];

  for (genvar k = 0; k < N; k++) begin : g_cell
    e2h_cordic_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (en_i),
      .vec_mode_i (1'b1),
      .step_i     (e2h_pkg::step_t'(k)),
      .x_i        (cx[k]),
      .y_i        (cy[k]),
      .z_i        (cz[k]),
      .x_o        (cx[k+1]),
      .y_o        (cy[k+1]),
      .z_o        (cz[k+1])
    );
  end

  assign z_o = cz[N];

endmodule

// ===== rtl/e2h_isqrt.sv =====
// Integer square root of a 64-bit value through a chain of digit cells.
// Depends on e2h_pkg and e2h_sqrt_cell.
module e2h_isqrt (
  input  logic            clk_i,
  input  logic            en_i,
  input  e2h_pkg::uwide_t v_i,
  output logic [31:0]     r_o
);

  localparam int N = e2h_pkg::SQRT_STEPS;

  e2h_pkg::uwide_t sv [N+1];
  e2h_pkg::uwide_t sr [N+1];

  assign sv[0] = v_i;
  assign sr[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    e2h_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .step_i (e2h_pkg::step_t'(k)),
      .v_i    (sv[k]),
      .r_i    (sr[k]),
      .v_o    (sv[k+1]),
      .r_o    (sr[k+1])
    );
  end

  assign r_o = sr[N][31:0];

endmodule

// ===== rtl/equatorial_to_horizontal.sv =====
// Equatorial to horizontal conversion: altitude and azimuth from RA, dec, LST, latitude.
// One item per cycle is taken whenever the pipeline advances. Each result passes through
// the CORDIC rotation chain, two square root chains and one vectoring chain in series.
// The whole pipeline advances when the output is free or taken.
// Reset clears the pipeline valid bits and sets the latitude register to zero.
// Depends on e2h_pkg, the channel interfaces, e2h_sincos, e2h_isqrt and e2h_vector.
module equatorial_to_horizontal (
  input  logic clk_i,
  input  logic rst_ni,
  e2h_in_if.sink    in_i,
  e2h_cfg_if.sink   cfg_i,
  e2h_out_if.source out_o
);

  localparam int L = e2h_pkg::TOTAL_LAT;

  logic           en;
  logic [L-1:0]   vld_q;
  e2h_pkg::q30_t  lat_cfg_q;
  e2h_pkg::turn_t lat_q, dec_q, ha_q;
  e2h_pkg::q30_t  sl, cl, sd, cd, sh, ch;

  e2h_pkg::wide_t p1_q, pc_q, t_q, p1b_q, sq_q, sum, sa_w;
  e2h_pkg::q30_t  ch1_q, sa_q, sa_d;
  e2h_pkg::trig_t tr1_q, tr2_q, tr3_q;
  e2h_pkg::side_t side4_q, side5_q;
  e2h_pkg::side_t side_q [e2h_pkg::SQRT_STEPS];
  e2h_pkg::uwide_t v_q;
  logic [31:0]    r1;
  e2h_pkg::q30_t  ca;
  e2h_pkg::side_t sx;
  e2h_pkg::cval_t zalt;
  e2h_pkg::q30_t  alt_q [e2h_pkg::ALT_DLY];

  e2h_pkg::wide_t   m1_q, m2_q, dd_q, nn_q;
  e2h_pkg::q30_t    sd1_q, d2_q, d_v;
  logic             shp1_q, shp2_q, shp3_q;
  e2h_pkg::nval_t   n2_q, n3_q, n_v;
  e2h_pkg::az_code_e code3_q, code_d;
  e2h_pkg::uwide_t  diff_q;
  e2h_pkg::az_side_t azs4_q;
  e2h_pkg::az_side_t azs_q [e2h_pkg::AZS_DLY];
  logic [31:0]      r2;
  e2h_pkg::cval_t   zaz;
  e2h_pkg::az_side_t azf;
  e2h_pkg::turn_t   az_sel, az_d, az_q;
  e2h_pkg::q30_t    alt_out_q;

  assign en          = !vld_q[L-1] || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      lat_cfg_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        lat_cfg_q <= cfg_i.observer_latitude;
      end
      if (en) begin
        vld_q <= {vld_q[L-2:0], in_i.valid};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_q <= e2h_pkg::turn_t'(lat_cfg_q);
      dec_q <= e2h_pkg::turn_t'(in_i.declination);
      ha_q  <= in_i.local_sidereal_time - in_i.right_ascension;
    end
  end

  e2h_sincos u_sc_lat (.clk_i(clk_i), .en_i(en), .a_i(lat_q), .sin_o(sl), .cos_o(cl));
  e2h_sincos u_sc_dec (.clk_i(clk_i), .en_i(en), .a_i(dec_q), .sin_o(sd), .cos_o(cd));
  e2h_sincos u_sc_ha  (.clk_i(clk_i), .en_i(en), .a_i(ha_q),  .sin_o(sh), .cos_o(ch));

  always_comb begin
    sum  = p1b_q + t_q;
    sa_w = sum >>> 30;
    if (sa_w > e2h_pkg::ONE_W) begin
      sa_d = e2h_pkg::q30_t'(e2h_pkg::ONE_W);
    end else if (sa_w < -e2h_pkg::ONE_W) begin
      sa_d = e2h_pkg::q30_t'(-e2h_pkg::ONE_W);
    end else begin
      sa_d = e2h_pkg::q30_t'(sa_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= e2h_pkg::wide_t'(sd) * e2h_pkg::wide_t'(sl);
      pc_q    <= e2h_pkg::wide_t'(cd) * e2h_pkg::wide_t'(cl);
      ch1_q   <= ch;
      tr1_q   <= '{sd: sd, sl: sl, cl: cl, sh_pos: (sh > 0)};
      t_q     <= e2h_pkg::wide_t'(e2h_pkg::q30_t'(pc_q >>> 30)) * e2h_pkg::wide_t'(ch1_q);
      p1b_q   <= p1_q;
      tr2_q   <= tr1_q;
      sa_q    <= sa_d;
      tr3_q   <= tr2_q;
      sq_q    <= e2h_pkg::wide_t'(sa_q) * e2h_pkg::wide_t'(sa_q);
      side4_q <= '{sa: sa_q, tg: tr3_q};
      v_q     <= e2h_pkg::ONE_SQ - e2h_pkg::uwide_t'(sq_q);
      side5_q <= side4_q;
      side_q[0] <= side5_q;
      for (int k = 1; k < e2h_pkg::SQRT_STEPS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  e2h_isqrt u_sqrt_alt (.clk_i(clk_i), .en_i(en), .v_i(v_q), .r_o(r1));

  assign ca = e2h_pkg::q30_t'(r1);
  assign sx = side_q[e2h_pkg::SQRT_STEPS-1];

  e2h_vector u_vec_alt (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (e2h_pkg::cval_t'(ca)),
    .y_i   (e2h_pkg::cval_t'(sx.sa)),
    .z_o   (zalt)
  );

  always_comb begin
    n_v = e2h_pkg::nval_t'(sd1_q) - e2h_pkg::nval_t'(m1_q >>> 30);
    d_v = e2h_pkg::q30_t'(m2_q >>> 30);
    if (d_v < 0) begin
      n_v = -n_v;
      d_v = -d_v;
    end
    if (d2_q == 0) begin
      code_d = (n2_q >= 0) ? e2h_pkg::AZ_ZERO : e2h_pkg::AZ_HALF;
    end else if (n2_q <= -e2h_pkg::nval_t'(d2_q)) begin
      code_d = e2h_pkg::AZ_HALF;
    end else if (n2_q >= e2h_pkg::nval_t'(d2_q)) begin
      code_d = e2h_pkg::AZ_ZERO;
    end else begin
      code_d = e2h_pkg::AZ_ACOS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q     <= e2h_pkg::wide_t'(sx.tg.sl) * e2h_pkg::wide_t'(sx.sa);
      m2_q     <= e2h_pkg::wide_t'(sx.tg.cl) * e2h_pkg::wide_t'(ca);
      sd1_q    <= sx.tg.sd;
      shp1_q   <= sx.tg.sh_pos;
      n2_q     <= n_v;
      d2_q     <= d_v;
      shp2_q   <= shp1_q;
      code3_q  <= code_d;
      n3_q     <= n2_q;
      dd_q     <= e2h_pkg::wide_t'(d2_q) * e2h_pkg::wide_t'(d2_q);
      nn_q     <= e2h_pkg::wide_t'(n2_q) * e2h_pkg::wide_t'(n2_q);
      shp3_q   <= shp2_q;
      diff_q   <= e2h_pkg::uwide_t'(dd_q - nn_q);
      azs4_q   <= '{n: n3_q, code: code3_q, sh_pos: shp3_q};
      azs_q[0] <= azs4_q;
      for (int k = 1; k < e2h_pkg::AZS_DLY; k++) begin
        azs_q[k] <= azs_q[k-1];
      end
      alt_q[0] <= e2h_pkg::clamp_q30(zalt);
      for (int k = 1; k < e2h_pkg::ALT_DLY; k++) begin
        alt_q[k] <= alt_q[k-1];
      end
    end
  end

  e2h_isqrt u_sqrt_az (.clk_i(clk_i), .en_i(en), .v_i(diff_q), .r_o(r2));

  e2h_vector u_vec_az (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (e2h_pkg::cval_t'(azs_q[e2h_pkg::SQRT_STEPS-1].n)),
    .y_i   ({{(e2h_pkg::CW-32){1'b0}}, r2}),
    .z_o   (zaz)
  );

  assign azf = azs_q[e2h_pkg::AZS_DLY-1];

  always_comb begin
    case (azf.code)
      e2h_pkg::AZ_ZERO: az_sel = '0;
      e2h_pkg::AZ_HALF: az_sel = e2h_pkg::HALF_TURN;
      default:          az_sel = zaz[31:0];
    endcase
    az_d = azf.sh_pos ? (32'd0 - az_sel) : az_sel;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q      <= az_d;
      alt_out_q <= alt_q[e2h_pkg::ALT_DLY-1];
    end
  end

  assign out_o.valid    = vld_q[L-1];
  assign out_o.altitude = alt_out_q;
  assign out_o.azimuth  = az_q;

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result stalled");

  a_accept_enters_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted item missing from pipeline");

  a_alt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.altitude <= 32'sh4000_0000 &&
                     out_o.altitude >= -32'sh4000_0000))
    else $error("altitude outside a quarter turn");

endmodule

// ===== sim/tb_e2h_if.sv =====
// Item types shared by the testbench: one sky position or latitude write, one result.
// Depends on nothing.
`timescale 1ns / 100ps
package tb_e2h_pkg;
  typedef struct packed {
    logic        is_cfg;
    logic [31:0] ra;
    logic [31:0] dec;
    logic [31:0] lst;
  } sky_item_t;

  typedef struct packed {
    logic [31:0] alt;
    logic [31:0] az;
  } horiz_t;
endpackage

// ===== sim/tb.sv =====
// Testbench for the equatorial to horizontal converter: random and directed star positions
// are predicted with integer CORDIC arithmetic and compared in order.
// Depends on e2h_pkg, the channel interfaces, the converter RTL and tb_e2h_pkg.
`timescale 1ns / 100ps
module tb;

  localparam longint ONE30 = 64'sd1073741824;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i;
  logic rst_ni;

  e2h_in_if  in_ch ();
  e2h_cfg_if cfg_ch ();
  e2h_out_if out_ch ();

  equatorial_to_horizontal dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  tb_e2h_pkg::sky_item_t stars_pending[$];
  tb_e2h_pkg::horiz_t    horizon_expected[$];
  logic [31:0] latitude_now;
  bit        calm;
  bit        failed;
  int        stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint asr_l(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sgn32(logic [31:0] a);
    return longint'($signed(a));
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint atan_step(int i);
    return longint'(e2h_pkg::atan_turn(e2h_pkg::step_t'(i)));
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void rotate(input logic [31:0] a, output longint sn, output longint cs);
    bit neg;
    longint x, y, z, dx, dy;
    neg = ((a + e2h_pkg::QUARTER_TURN) & e2h_pkg::HALF_TURN) != 0;
    x = 652032874;
    y = 0;
    if (neg) a = a - e2h_pkg::HALF_TURN;
    z = sgn32(a);
    for (int i = 0; i < 30; i++) begin
      dx = asr_l(y, i);
      dy = asr_l(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    x = clip(x, ONE30);
    y = clip(y, ONE30);
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, t, dx, dy, lim;
    z = 0;
    lim = ONE30 / 2;
    if (x < 0) begin
      t = x; x = y; y = -t; z = e2h_pkg::QUARTER_TURN;
    end
    while (x < lim && y < lim && y > -lim && (x != 0 || y != 0)) begin
      x *= 2; y *= 2;
    end
    for (int i = 0; i < 30; i++) begin
      dx = asr_l(y, i);
      dy = asr_l(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic tb_e2h_pkg::horiz_t to_horizon(tb_e2h_pkg::sky_item_t s,
                                                    logic [31:0] lat);
    longint sl, cl, sd, cd, sh, ch, sa, ca, n, d, alt;
    logic [31:0] az;
    tb_e2h_pkg::horiz_t h;
    rotate(lat, sl, cl);
    rotate(s.dec, sd, cd);
    rotate(s.lst - s.ra, sh, ch);
    sa = clip(asr_l(sd * sl + asr_l(cd * cl, 30) * ch, 30), ONE30);
    ca = root64(longint'(ONE30 * ONE30 - sa * sa));
    alt = clip(vector_angle(ca, sa), longint'(e2h_pkg::QUARTER_TURN));
    n = sd - asr_l(sl * sa, 30);
    d = asr_l(cl * ca, 30);
    if (d < 0) begin
      n = -n; d = -d;
    end
    if (d == 0) az = n >= 0 ? 32'd0 : e2h_pkg::HALF_TURN;
    else if (n <= -d) az = e2h_pkg::HALF_TURN;
    else if (n >= d) az = 32'd0;
    else az = 32'(vector_angle(n, root64(longint'(d * d - n * n))));
    if (sh > 0) az = 32'd0 - az;
    h.alt = alt[31:0];
    h.az = az;
    return h;
  endfunction

  function automatic logic [31:0] rand_signed_angle();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return $urandom;
      3: return 32'(-$signed({1'b0, $urandom_range(16)}));
      default: return 32'($signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
    endcase
  endfunction

  task automatic push_star(logic [31:0] ra, logic [31:0] dec, logic [31:0] lst);
    tb_e2h_pkg::sky_item_t s;
    s.is_cfg = 1'b0; s.ra = ra; s.dec = dec; s.lst = lst;
    stars_pending.push_back(s);
  endtask

  task automatic push_latitude(logic [31:0] lat);
    tb_e2h_pkg::sky_item_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.dec = lat;
    stars_pending.push_back(s);
  endtask

  // Stimulus is laid out in phases separated by latitude writes.
  initial begin
    logic [31:0] lats[6];
    lats = '{32'h4000_0000, 32'hC000_0000, 32'h0, 32'h1555_5555, 32'hFFFF_FFFF, 32'h2AAA_0000};
    push_star(32'h0, 32'h0, 32'h0);
    push_star(32'hFFFF_FFFF, 32'h4000_0000, 32'h0);
    push_star(32'h0, 32'hC000_0000, 32'hFFFF_FFFF);
    push_star(32'h8000_0000, 32'h0, 32'h0);
    push_star(32'h4000_0000, 32'h0, 32'h0);
    push_star(32'h0, 32'h0, 32'h4000_0000);
    push_star(32'h1234_5678, 32'h8000_0000, 32'h9ABC_DEF0);
    push_star(32'h0, 32'h7FFF_FFFF, 32'h0);
    for (int p = 0; p < 6; p++) begin
      push_latitude(lats[p]);
      push_star(32'h0, 32'h0, 32'h0);
      push_star(32'h0, lats[p], 32'h0);
      push_star(32'h0, 32'h0 - lats[p], 32'h8000_0000);
      push_star(32'h0, 32'h4000_0000, 32'h0);
      for (int k = 0; k < 240; k++) push_star($urandom, rand_signed_angle(), $urandom);
    end
    push_latitude(rand_signed_angle());
    for (int k = 0; k < 60; k++) push_star($urandom, rand_signed_angle(), $urandom);
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.right_ascension = '0;
    in_ch.declination = '0;
    in_ch.local_sidereal_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.observer_latitude = '0;
    out_ch.ready = 1'b0;
    latitude_now = '0;
    failed = 1'b0;
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  int cyc;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    calm <= (cyc % 1000) < 200;
  end

  // Driver: one step per falling edge, handshakes were seen at the preceding rising edge.
  bit in_took, cfg_took;
  always @(posedge clk_i) begin
    in_took  <= in_ch.valid && in_ch.ready;
    cfg_took <= cfg_ch.valid && cfg_ch.ready;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ch.ready <= calm || ($urandom_range(99) >= 25);
      if (in_took) begin
        horizon_expected.push_back(to_horizon(stars_pending.pop_front(), latitude_now));
      end
      if (cfg_took) begin
        latitude_now = stars_pending[0].dec;
        void'(stars_pending.pop_front());
      end
      if (!in_took && !cfg_took && in_ch.valid) begin
        in_ch.valid <= 1'b1;
      end else if (!cfg_took && cfg_ch.valid) begin
        cfg_ch.valid <= 1'b1;
      end else if (stars_pending.size() == 0) begin
        in_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end else if (stars_pending[0].is_cfg) begin
        in_ch.valid <= 1'b0;
        if (horizon_expected.size() == 0 && !in_took && !in_ch.valid) begin
          cfg_ch.valid <= 1'b1;
          cfg_ch.observer_latitude <= stars_pending[0].dec;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end else if (calm || $urandom_range(99) >= 25) begin
        cfg_ch.valid <= 1'b0;
        in_ch.valid <= 1'b1;
        in_ch.right_ascension <= stars_pending[0].ra;
        in_ch.declination <= stars_pending[0].dec;
        in_ch.local_sidereal_time <= stars_pending[0].lst;
      end else begin
        cfg_ch.valid <= 1'b0;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    tb_e2h_pkg::horiz_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (horizon_expected.size() == 0) begin
        $display("%0t: result with nothing expected: alt %h az %h", $time,
                 out_ch.altitude, out_ch.azimuth);
        failed = 1'b1;
      end else begin
        want = horizon_expected.pop_front();
        if (want.alt !== out_ch.altitude) begin
          $display("%0t: altitude expected %h actual %h", $time, want.alt, out_ch.altitude);
          failed = 1'b1;
        end
        if (want.az !== out_ch.azimuth) begin
          $display("%0t: azimuth expected %h actual %h", $time, want.az, out_ch.azimuth);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
        || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cyc = 0;
    wait (rst_ni);
    fork
      begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
      end
      begin
        @(posedge clk_i);
        while (stars_pending.size() != 0 || in_ch.valid || cfg_ch.valid || in_took
               || horizon_expected.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
      end
    join_any
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
    end else if (!failed && horizon_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
